>>> rtl/rmj_pkg.sv
// Shared constants, types and helpers for the range median-jump EMA filter.
// Used by every module in the rtl folder; has no dependencies of its own.

package rmj_pkg;

    // Geometry
    localparam int WIN_DEPTH    = 8;    // frames kept per anchor
    localparam int ANCHOR_SLOTS = 8;    // anchor distance lanes per frame
    localparam int DIST_W       = 16;
    localparam int ROW_W        = $clog2(WIN_DEPTH);
    localparam int ANC_W        = (ANCHOR_SLOTS > 1) ? $clog2(ANCHOR_SLOTS) : 1;
    localparam int CNT_W        = $clog2(WIN_DEPTH + 1);
    localparam int ACNT_W       = $clog2(ANCHOR_SLOTS + 1);
    localparam int FH_W         = 4;
    localparam int MEM_AW       = ANC_W + ROW_W;
    localparam int MEM_DEPTH    = 1 << MEM_AW;

    // Filter behavior
    localparam int WARM_FRAMES  = 3;    // frames_held below this passes raw data
    localparam int MIN_HIST     = 2;    // fewest valid entries for a median

    // Moving average fixed point
    localparam int FRAC_W       = 8;
    localparam int EMA_W        = DIST_W + FRAC_W;
    localparam int ALPHA_W      = 9;
    localparam int ALPHA_ONE    = 1 << FRAC_W;
    localparam int PROD_W       = ALPHA_W + EMA_W;

    // Register port
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;
    localparam int AIU_W        = 4;
    localparam int AIU_RST      = 8;
    localparam int JUMP_RST     = 500;
    localparam int ALPHA_RST    = 128;
    localparam int VMAX_RST     = 50000;

    typedef logic [DIST_W-1:0] dist_t;

    typedef enum logic [1:0] {
        REG_ANCHORS   = 2'd0,
        REG_MAX_JUMP  = 2'd1,
        REG_ALPHA     = 2'd2,
        REG_VALID_MAX = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } seq_state_t;

    // Insert command broadcast along the sorting chain
    typedef struct packed {
        logic  ins;
        logic  restart;
        dist_t value;
    } sort_ctl_t;

    // Sorted window summary
    typedef struct packed {
        logic [CNT_W-1:0] count;
        dist_t            median;
    } sort_res_t;

    // Moving average request and response
    typedef struct packed {
        logic             vld;
        logic [ANC_W-1:0] anc;
        dist_t            reading;
    } ema_req_t;

    typedef struct packed {
        logic             vld;
        logic [ANC_W-1:0] anc;
        dist_t            value;
        logic             busy;
    } ema_rsp_t;

    // A reading is usable when nonzero and below the valid bound
    function automatic logic is_valid(input dist_t d, input dist_t vmax);
        return (d != '0) && (d < vmax);
    endfunction

endpackage

>>> rtl/rmj_sort_cell.sv
// One cell of the insertion sorting chain: holds one window entry.
// Depends on rmj_pkg for the distance type and the insert command struct.

module rmj_sort_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  rmj_pkg::sort_ctl_t ctl,
    input  logic              left_gt,
    input  rmj_pkg::dist_t    left_val,
    input  logic              left_occ,
    output logic              gt,
    output rmj_pkg::dist_t    val,
    output logic              occ
);

    rmj_pkg::dist_t val_reg;
    logic           occ_reg;

    // a restart empties the chain before the new value goes in
    assign occ = occ_reg & ~ctl.restart;
    assign gt  = ~occ | (ctl.value < val_reg);
    assign val = val_reg;

    // occupancy: take the left neighbor's entry when it also shifts, else the new one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else if (ctl.ins && gt)
        begin
            occ_reg <= left_gt ? left_occ : 1'b1;
        end
        else if (ctl.restart)
        begin
            occ_reg <= 1'b0;
        end
    end

    // value
    always_ff @(posedge clk)
    begin
        if (ctl.ins && gt)
        begin
            val_reg <= left_gt ? left_val : ctl.value;
        end
    end

endmodule

>>> rtl/rmj_sorter.sv
// Chain of sort cells kept in ascending order, plus entry count and median.
// Depends on rmj_pkg and rmj_sort_cell.

module rmj_sorter (
    input  logic                clk,
    input  logic                rst_n,
    input  rmj_pkg::sort_ctl_t  ctl,
    output rmj_pkg::sort_res_t  res
);

    logic                 gt_w  [rmj_pkg::WIN_DEPTH];
    logic                 occ_w [rmj_pkg::WIN_DEPTH];
    rmj_pkg::dist_t       val_w [rmj_pkg::WIN_DEPTH];
    logic [rmj_pkg::CNT_W-1:0] cnt_reg;

    logic [rmj_pkg::ROW_W-1:0]  hi_idx;
    logic [rmj_pkg::ROW_W-1:0]  lo_idx;
    logic [rmj_pkg::DIST_W:0]   mid_sum;

    // the row of cells; cell 0 holds the smallest entry
    for (genvar k = 0; k < rmj_pkg::WIN_DEPTH; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            rmj_sort_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .left_gt  (1'b0),
                .left_val ('0),
                .left_occ (1'b0),
                .gt       (gt_w[k]),
                .val      (val_w[k]),
                .occ      (occ_w[k])
            );
        end
        else
        begin : g_body
            rmj_sort_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .left_gt  (gt_w[k-1]),
                .left_val (val_w[k-1]),
                .left_occ (occ_w[k-1]),
                .gt       (gt_w[k]),
                .val      (val_w[k]),
                .occ      (occ_w[k])
            );
        end
    end

    // number of valid entries held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.ins)
        begin
            cnt_reg <= (ctl.restart ? '0 : cnt_reg) + 1'b1;
        end
        else if (ctl.restart)
        begin
            cnt_reg <= '0;
        end
    end

    // median: middle entry, or floor mean of the two middle entries
    always_comb
    begin
        hi_idx     = rmj_pkg::ROW_W'(cnt_reg >> 1);
        lo_idx     = hi_idx - 1'b1;
        mid_sum    = {1'b0, val_w[hi_idx]} + {1'b0, val_w[lo_idx]};
        res.count  = cnt_reg;
        res.median = cnt_reg[0] ? val_w[hi_idx] : mid_sum[rmj_pkg::DIST_W:1];
    end

endmodule

>>> rtl/rmj_ema.sv
// Per-anchor exponential moving average, 16.8 fixed point, three stages.
// Depends on rmj_pkg for widths and the request/response structs.

module rmj_ema (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rmj_pkg::ema_req_t           req,
    input  logic [rmj_pkg::ALPHA_W-1:0] alpha,
    output rmj_pkg::ema_rsp_t           rsp
);

    localparam int EW = rmj_pkg::EMA_W;
    localparam int PW = rmj_pkg::PROD_W;
    localparam int FW = rmj_pkg::FRAC_W;

    logic [EW-1:0] sv_reg     [rmj_pkg::ANCHOR_SLOTS];
    logic          seeded_reg [rmj_pkg::ANCHOR_SLOTS];

    logic [rmj_pkg::ALPHA_W-1:0] alpha_eff;
    logic [EW-1:0]               target;
    logic [EW-1:0]               cur;
    logic                        up;
    logic [EW-1:0]               diff;

    // stage 1: difference to the target
    logic                        e1_vld_reg;
    logic [rmj_pkg::ANC_W-1:0]   e1_anc_reg;
    logic                        e1_seed_reg;
    logic                        e1_up_reg;
    logic [EW-1:0]               e1_diff_reg;
    logic [EW-1:0]               e1_cur_reg;
    logic [EW-1:0]               e1_target_reg;
    logic [rmj_pkg::ALPHA_W-1:0] e1_alpha_reg;

    // stage 2: scaled step
    logic                        e2_vld_reg;
    logic [rmj_pkg::ANC_W-1:0]   e2_anc_reg;
    logic                        e2_seed_reg;
    logic                        e2_up_reg;
    logic [PW-1:0]               e2_prod_reg;
    logic [EW-1:0]               e2_cur_reg;
    logic [EW-1:0]               e2_target_reg;

    logic [PW:0]                 round_sum;
    logic [EW+1:0]               step_up;
    logic [EW+1:0]               step_dn;
    logic [EW+1:0]               sum_full;
    logic [EW-1:0]               new_val;

    // gain saturates at one
    always_comb
    begin
        alpha_eff = (alpha > rmj_pkg::ALPHA_W'(rmj_pkg::ALPHA_ONE))
                  ? rmj_pkg::ALPHA_W'(rmj_pkg::ALPHA_ONE) : alpha;
        target    = {req.reading, {FW{1'b0}}};
        cur       = sv_reg[req.anc];
        up        = (target >= cur);
        diff      = up ? (target - cur) : (cur - target);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
        end
        else
        begin
            e1_vld_reg <= req.vld;
            e2_vld_reg <= e1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_anc_reg    <= req.anc;
        e1_seed_reg   <= ~seeded_reg[req.anc];
        e1_up_reg     <= up;
        e1_diff_reg   <= diff;
        e1_cur_reg    <= cur;
        e1_target_reg <= target;
        e1_alpha_reg  <= alpha_eff;

        e2_anc_reg    <= e1_anc_reg;
        e2_seed_reg   <= e1_seed_reg;
        e2_up_reg     <= e1_up_reg;
        e2_prod_reg   <= PW'(e1_alpha_reg) * PW'(e1_diff_reg);
        e2_cur_reg    <= e1_cur_reg;
        e2_target_reg <= e1_target_reg;
    end

    // stage 3: step toward target; downward steps round toward minus infinity
    always_comb
    begin
        round_sum = {1'b0, e2_prod_reg} + (PW+1)'(rmj_pkg::ALPHA_ONE - 1);
        step_up   = (EW+2)'(e2_prod_reg[PW-1:FW]);
        step_dn   = (EW+2)'(round_sum[PW:FW]);
        if (e2_up_reg)
        begin
            sum_full = (EW+2)'(e2_cur_reg) + step_up;
        end
        else
        begin
            sum_full = (EW+2)'(e2_cur_reg) - step_dn;
        end
        new_val = e2_seed_reg ? e2_target_reg : sum_full[EW-1:0];
    end

    // per-anchor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < rmj_pkg::ANCHOR_SLOTS; a++)
            begin
                sv_reg[a]     <= '0;
                seeded_reg[a] <= 1'b0;
            end
        end
        else if (e2_vld_reg)
        begin
            sv_reg[e2_anc_reg]     <= new_val;
            seeded_reg[e2_anc_reg] <= 1'b1;
        end
    end

    assign rsp.vld   = e2_vld_reg;
    assign rsp.anc   = e2_anc_reg;
    assign rsp.value = new_val[EW-1:FW];
    assign rsp.busy  = e1_vld_reg | e2_vld_reg;

endmodule

>>> rtl/range_median_jump_ema_filter_unit.sv
// Top level of the range median-jump EMA filter: register port, sequencer,
// window memory and result registers. Depends on rmj_pkg, rmj_sorter, rmj_ema.

// A frame is accepted in idle, then each of the N active anchors (N being the
// active anchor count) is handled in turn: the new reading and the seven older
// window entries are fed, one per cycle from the single read port of the window
// memory, into the sorting chain. The median and moving average stages then drain,
// and the frame is handed to the output register. A finished frame
// waits in the output register, so the next frame can be taken while it is
// still unread. Warm-up frames and frames with no active anchor take the same
// sequence (or only the drain) and return readings unchanged.

module range_median_jump_ema_filter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rmj_pkg::PADDR_W-1:0]   paddr,
    input  logic [rmj_pkg::PDATA_W-1:0]   pwdata,
    output logic [rmj_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // input frames
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rmj_pkg::DIST_W-1:0]    dist_a0,
    input  logic [rmj_pkg::DIST_W-1:0]    dist_a1,
    input  logic [rmj_pkg::DIST_W-1:0]    dist_a2,
    input  logic [rmj_pkg::DIST_W-1:0]    dist_a3,
    input  logic [rmj_pkg::DIST_W-1:0]    dist_a4,
    input  logic [rmj_pkg::DIST_W-1:0]    dist_a5,
    input  logic [rmj_pkg::DIST_W-1:0]    dist_a6,
    input  logic [rmj_pkg::DIST_W-1:0]    dist_a7,
    // filtered frames
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rmj_pkg::DIST_W-1:0]    filt_a0,
    output logic [rmj_pkg::DIST_W-1:0]    filt_a1,
    output logic [rmj_pkg::DIST_W-1:0]    filt_a2,
    output logic [rmj_pkg::DIST_W-1:0]    filt_a3,
    output logic [rmj_pkg::DIST_W-1:0]    filt_a4,
    output logic [rmj_pkg::DIST_W-1:0]    filt_a5,
    output logic [rmj_pkg::DIST_W-1:0]    filt_a6,
    output logic [rmj_pkg::DIST_W-1:0]    filt_a7
);

    localparam int RW = rmj_pkg::ROW_W;
    localparam int AW = rmj_pkg::ANC_W;
    localparam int NA = rmj_pkg::ANCHOR_SLOTS;

    // ---------------- configuration registers ----------------
    logic [rmj_pkg::AIU_W-1:0]   cfg_anchors_reg;
    rmj_pkg::dist_t              cfg_max_jump_reg;
    logic [rmj_pkg::ALPHA_W-1:0] cfg_alpha_reg;
    rmj_pkg::dist_t              cfg_valid_max_reg;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_anchors_reg   <= rmj_pkg::AIU_W'(rmj_pkg::AIU_RST);
            cfg_max_jump_reg  <= rmj_pkg::DIST_W'(rmj_pkg::JUMP_RST);
            cfg_alpha_reg     <= rmj_pkg::ALPHA_W'(rmj_pkg::ALPHA_RST);
            cfg_valid_max_reg <= rmj_pkg::DIST_W'(rmj_pkg::VMAX_RST);
        end
        else if (cfg_wr)
        begin
            case (rmj_pkg::cfg_reg_t'(paddr[3:2]))
                rmj_pkg::REG_ANCHORS:   cfg_anchors_reg   <= pwdata[rmj_pkg::AIU_W-1:0];
                rmj_pkg::REG_MAX_JUMP:  cfg_max_jump_reg  <= pwdata[rmj_pkg::DIST_W-1:0];
                rmj_pkg::REG_ALPHA:     cfg_alpha_reg     <= pwdata[rmj_pkg::ALPHA_W-1:0];
                rmj_pkg::REG_VALID_MAX: cfg_valid_max_reg <= pwdata[rmj_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (rmj_pkg::cfg_reg_t'(paddr[3:2]))
            rmj_pkg::REG_ANCHORS:   prdata = rmj_pkg::PDATA_W'(cfg_anchors_reg);
            rmj_pkg::REG_MAX_JUMP:  prdata = rmj_pkg::PDATA_W'(cfg_max_jump_reg);
            rmj_pkg::REG_ALPHA:     prdata = rmj_pkg::PDATA_W'(cfg_alpha_reg);
            rmj_pkg::REG_VALID_MAX: prdata = rmj_pkg::PDATA_W'(cfg_valid_max_reg);
            default:                prdata = '0;
        endcase
    end

    // ---------------- frame state ----------------
    rmj_pkg::seq_state_t           state_reg, state_next;
    logic [AW-1:0]                 anc_reg;
    logic [RW-1:0]                 slot_reg;
    logic [rmj_pkg::ACNT_W-1:0]    count_reg;
    logic [rmj_pkg::ACNT_W-1:0]    count_calc;
    logic [rmj_pkg::FH_W-1:0]      frames_held_reg;
    logic [rmj_pkg::FH_W-1:0]      fh_old_reg;
    logic [rmj_pkg::FH_W-1:0]      fh_new;
    logic                          full_reg;
    logic                          warm_reg;
    rmj_pkg::dist_t                dist_reg [NA];
    rmj_pkg::dist_t                res_reg  [NA];
    rmj_pkg::dist_t                filt_reg [NA];
    logic [RW-1:0]                 head_reg [NA];
    logic [RW-1:0]                 head_inc;
    logic                          out_valid_reg, out_valid_next;
    rmj_pkg::dist_t                dist_in [NA];
    rmj_pkg::ema_rsp_t             ema_rsp;

    logic                          accept;
    logic                          issue;
    logic                          load_out;
    logic                          slot_last;
    logic                          anc_last;
    logic                          pipe_busy;

    assign dist_in[0] = dist_a0;
    assign dist_in[1] = dist_a1;
    assign dist_in[2] = dist_a2;
    assign dist_in[3] = dist_a3;
    assign dist_in[4] = dist_a4;
    assign dist_in[5] = dist_a5;
    assign dist_in[6] = dist_a6;
    assign dist_in[7] = dist_a7;

    // anchor count saturates at the lane count
    always_comb
    begin
        count_calc = (cfg_anchors_reg > rmj_pkg::AIU_W'(NA))
                   ? rmj_pkg::ACNT_W'(NA) : rmj_pkg::ACNT_W'(cfg_anchors_reg);
        fh_new     = (frames_held_reg == rmj_pkg::FH_W'(rmj_pkg::WIN_DEPTH))
                   ? frames_held_reg : frames_held_reg + 1'b1;
        slot_last  = (slot_reg == RW'(rmj_pkg::WIN_DEPTH - 1));
        anc_last   = ((rmj_pkg::ACNT_W'(anc_reg) + 1'b1) == count_reg);
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        accept     = 1'b0;
        issue      = 1'b0;
        load_out   = 1'b0;
        in_ready   = 1'b0;
        case (state_reg)
            rmj_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    accept     = 1'b1;
                    state_next = (count_calc == '0) ? rmj_pkg::ST_DRAIN : rmj_pkg::ST_RUN;
                end
            end
            rmj_pkg::ST_RUN:
            begin
                issue = 1'b1;
                if (slot_last && anc_last)
                begin
                    state_next = rmj_pkg::ST_DRAIN;
                end
            end
            rmj_pkg::ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = rmj_pkg::ST_DONE;
                end
            end
            rmj_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = rmj_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmj_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rmj_pkg::ST_IDLE;
            out_valid_reg   <= 1'b0;
            frames_held_reg <= '0;
            anc_reg         <= '0;
            slot_reg        <= '0;
            for (int a = 0; a < NA; a++)
            begin
                head_reg[a] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                frames_held_reg <= fh_new;
                anc_reg         <= '0;
                slot_reg        <= '0;
            end
            else if (issue)
            begin
                if (slot_last)
                begin
                    slot_reg <= '0;
                    anc_reg  <= anc_reg + 1'b1;
                end
                else
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
            // oldest row moves on once the window is full, after the anchor's reads
            if (issue && slot_last && full_reg)
            begin
                head_reg[anc_reg] <= head_inc;
            end
        end
    end

    // frame payload and per-frame flags
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            count_reg  <= count_calc;
            fh_old_reg <= frames_held_reg;
            full_reg   <= (frames_held_reg == rmj_pkg::FH_W'(rmj_pkg::WIN_DEPTH));
            warm_reg   <= (fh_new < rmj_pkg::FH_W'(rmj_pkg::WARM_FRAMES));
            for (int a = 0; a < NA; a++)
            begin
                dist_reg[a] <= dist_in[a];
                res_reg[a]  <= dist_in[a];
            end
        end
        else if (ema_rsp.vld)
        begin
            res_reg[ema_rsp.anc] <= ema_rsp.value;
        end
        if (load_out)
        begin
            for (int a = 0; a < NA; a++)
            begin
                filt_reg[a] <= res_reg[a];
            end
        end
    end

    // ---------------- window memory ----------------
    rmj_pkg::dist_t              hist_mem [rmj_pkg::MEM_DEPTH];
    rmj_pkg::dist_t              rd_data_reg;
    rmj_pkg::dist_t              cur_dist;
    logic [RW-1:0]               wr_row;
    logic [RW-1:0]               rd_row;
    logic [RW:0]                 row_sum;
    logic [RW:0]                 head_sum;
    logic                        rd_use;

    // physical rows: write row is the oldest (full) or the next free one
    always_comb
    begin
        cur_dist = dist_reg[anc_reg];
        wr_row   = full_reg ? head_reg[anc_reg] : fh_old_reg[RW-1:0];
        row_sum  = {1'b0, wr_row} + (RW+1)'(slot_reg);
        rd_row   = (row_sum >= (RW+1)'(rmj_pkg::WIN_DEPTH))
                 ? RW'(row_sum - (RW+1)'(rmj_pkg::WIN_DEPTH)) : row_sum[RW-1:0];
        head_sum = {1'b0, head_reg[anc_reg]} + 1'b1;
        head_inc = (head_sum == (RW+1)'(rmj_pkg::WIN_DEPTH)) ? '0 : head_sum[RW-1:0];
        rd_use   = full_reg || (rmj_pkg::FH_W'(rd_row) < fh_old_reg);
    end

    always_ff @(posedge clk)
    begin
        if (issue && slot_reg == '0)
        begin
            hist_mem[{anc_reg, wr_row}] <= cur_dist;
        end
        rd_data_reg <= hist_mem[{anc_reg, rd_row}];
    end

    // ---------------- feed stage into the sorting chain ----------------
    logic               s1_vld_reg;
    logic               s1_first_reg;
    logic               s1_last_reg;
    logic               s1_use_reg;
    logic [AW-1:0]      s1_anc_reg;
    rmj_pkg::dist_t     s1_raw_reg;
    rmj_pkg::dist_t     feed_val;
    rmj_pkg::sort_ctl_t sort_ctl;
    rmj_pkg::sort_res_t sort_res;

    logic               sd_vld_reg;
    logic [AW-1:0]      sd_anc_reg;
    rmj_pkg::dist_t     raw_hold_reg;

    logic               m_vld_reg;
    logic               m_ok_reg;
    logic [AW-1:0]      m_anc_reg;
    rmj_pkg::dist_t     m_med_reg;
    rmj_pkg::dist_t     m_raw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            sd_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= issue;
            sd_vld_reg <= s1_vld_reg & s1_last_reg;
            m_vld_reg  <= sd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= (slot_reg == '0);
        s1_last_reg  <= slot_last;
        s1_use_reg   <= (slot_reg == '0) | rd_use;
        s1_anc_reg   <= anc_reg;
        s1_raw_reg   <= cur_dist;
        sd_anc_reg   <= s1_anc_reg;
        if (s1_vld_reg && s1_first_reg)
        begin
            raw_hold_reg <= s1_raw_reg;
        end
        m_anc_reg <= sd_anc_reg;
        m_med_reg <= sort_res.median;
        m_ok_reg  <= (sort_res.count >= rmj_pkg::CNT_W'(rmj_pkg::MIN_HIST));
        m_raw_reg <= raw_hold_reg;
    end

    // first slot carries the new reading, the rest come from memory
    always_comb
    begin
        feed_val         = s1_first_reg ? s1_raw_reg : rd_data_reg;
        sort_ctl.value   = feed_val;
        sort_ctl.restart = s1_vld_reg & s1_first_reg;
        sort_ctl.ins     = s1_vld_reg & s1_use_reg
                         & rmj_pkg::is_valid(feed_val, cfg_valid_max_reg);
    end

    rmj_sorter u_sorter (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sort_ctl),
        .res   (sort_res)
    );

    // ---------------- jump check ----------------
    rmj_pkg::dist_t     dev;
    rmj_pkg::ema_req_t  ema_req;

    always_comb
    begin
        dev             = (m_raw_reg > m_med_reg) ? (m_raw_reg - m_med_reg)
                                                  : (m_med_reg - m_raw_reg);
        ema_req.vld     = m_vld_reg & m_ok_reg & ~warm_reg
                        & rmj_pkg::is_valid(m_raw_reg, cfg_valid_max_reg);
        ema_req.anc     = m_anc_reg;
        ema_req.reading = (dev > cfg_max_jump_reg) ? m_med_reg : m_raw_reg;
    end

    rmj_ema u_ema (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ema_req),
        .alpha (cfg_alpha_reg),
        .rsp   (ema_rsp)
    );

    assign pipe_busy = s1_vld_reg | sd_vld_reg | m_vld_reg | ema_rsp.busy | ema_rsp.vld;

    // ---------------- outputs ----------------
    assign out_valid = out_valid_reg;
    assign filt_a0   = filt_reg[0];
    assign filt_a1   = filt_reg[1];
    assign filt_a2   = filt_reg[2];
    assign filt_a3   = filt_reg[3];
    assign filt_a4   = filt_reg[4];
    assign filt_a5   = filt_reg[5];
    assign filt_a6   = filt_reg[6];
    assign filt_a7   = filt_reg[7];

endmodule

>>> tb/range_median_jump_ema_filter_unit_tb.sv
// Self-checking testbench for range_median_jump_ema_filter_unit.
// Depends on rmj_pkg and the filter RTL; holds its own predictor of the window,
// median jump check and moving average, and compares every output frame with it.

module range_median_jump_ema_filter_unit_tb;

    localparam int LIMIT_CYCLES  = 500000;
    localparam int SETTLE_CYCLES = 100;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_FRAMES  = 100;
    localparam int HOLD_CYCLES   = 400;

    typedef logic [rmj_pkg::ANCHOR_SLOTS-1:0][rmj_pkg::DIST_W-1:0] frame_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [rmj_pkg::PADDR_W-1:0] paddr;
    logic [rmj_pkg::PDATA_W-1:0] pwdata;
    logic [rmj_pkg::PDATA_W-1:0] prdata;
    logic pready;
    logic in_valid;
    logic in_ready;
    logic out_valid;
    logic out_ready;
    frame_t dist_drive;
    wire [rmj_pkg::ANCHOR_SLOTS-1:0][rmj_pkg::DIST_W-1:0] filt_seen;

    // Predictor state: window, fill level, per-anchor average
    rmj_pkg::dist_t win_hist [rmj_pkg::WIN_DEPTH][rmj_pkg::ANCHOR_SLOTS];
    int unsigned win_frames;
    logic [rmj_pkg::EMA_W-1:0] avg_q8 [rmj_pkg::ANCHOR_SLOTS];
    bit avg_seeded [rmj_pkg::ANCHOR_SLOTS];

    // Predictor copy of the registers
    logic [rmj_pkg::AIU_W-1:0] cfg_anchors;
    logic [rmj_pkg::DIST_W-1:0] cfg_jump;
    logic [rmj_pkg::ALPHA_W-1:0] cfg_alpha;
    logic [rmj_pkg::DIST_W-1:0] cfg_vmax;

    frame_t pending_frames[$];
    int lane_base [rmj_pkg::ANCHOR_SLOTS];
    int err_count;
    int cycle_count;
    int hold_req;
    bit fast_mode;

    range_median_jump_ema_filter_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .dist_a0   (dist_drive[0]),
        .dist_a1   (dist_drive[1]),
        .dist_a2   (dist_drive[2]),
        .dist_a3   (dist_drive[3]),
        .dist_a4   (dist_drive[4]),
        .dist_a5   (dist_drive[5]),
        .dist_a6   (dist_drive[6]),
        .dist_a7   (dist_drive[7]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .filt_a0   (filt_seen[0]),
        .filt_a1   (filt_seen[1]),
        .filt_a2   (filt_seen[2]),
        .filt_a3   (filt_seen[3]),
        .filt_a4   (filt_seen[4]),
        .filt_a5   (filt_seen[5]),
        .filt_a6   (filt_seen[6]),
        .filt_a7   (filt_seen[7])
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("range_median_jump_ema_filter_unit: mismatch");
            $finish;
        end
    end

    function automatic bit reading_ok(int unsigned d);
        return (d > 0) && (d < cfg_vmax);
    endfunction

    // Expected output frame for one accepted input frame; updates predictor state
    function automatic frame_t filter_frame(frame_t raw);
        frame_t res;
        int unsigned lanes, n, med, r, dev, x, j;
        int unsigned vals [rmj_pkg::WIN_DEPTH];
        longint unsigned tgt, cur, g, p;
        bit warm;
        res = raw;
        lanes = (cfg_anchors > rmj_pkg::ANCHOR_SLOTS) ? rmj_pkg::ANCHOR_SLOTS : cfg_anchors;

        // push into the window, shifting once it is full
        if (win_frames < rmj_pkg::WIN_DEPTH)
        begin
            for (int i = 0; i < lanes; i++)
                win_hist[win_frames][i] = raw[i];
            win_frames++;
            warm = (win_frames < 3);
        end
        else
        begin
            for (int w = 0; w < rmj_pkg::WIN_DEPTH - 1; w++)
                for (int i = 0; i < lanes; i++)
                    win_hist[w][i] = win_hist[w + 1][i];
            for (int i = 0; i < lanes; i++)
                win_hist[rmj_pkg::WIN_DEPTH - 1][i] = raw[i];
            warm = 1'b0;
        end

        if (!warm)
        begin
            for (int i = 0; i < lanes; i++)
            begin
                r = raw[i];
                n = 0;
                if (reading_ok(r))
                begin
                    for (int w = 0; w < win_frames; w++)
                    begin
                        if (reading_ok(win_hist[w][i]))
                        begin
                            vals[n] = win_hist[w][i];
                            n++;
                        end
                    end
                end
                // needs two valid history entries for a median
                if (n >= 2)
                begin
                    for (int k = 1; k < n; k++)
                    begin
                        x = vals[k];
                        j = k;
                        while (j > 0 && vals[j - 1] > x)
                        begin
                            vals[j] = vals[j - 1];
                            j--;
                        end
                        vals[j] = x;
                    end
                    if (n % 2 == 1)
                        med = vals[n / 2];
                    else
                        med = (vals[n / 2 - 1] + vals[n / 2]) >> 1;
                    dev = (r > med) ? r - med : med - r;
                    if (dev > cfg_jump)
                        r = med;

                    // moving average, 8 fraction bits, floor on the way down
                    tgt = longint'(r) << 8;
                    g = (cfg_alpha > rmj_pkg::ALPHA_ONE) ? rmj_pkg::ALPHA_ONE : cfg_alpha;
                    cur = avg_q8[i];
                    if (!avg_seeded[i])
                    begin
                        cur = tgt;
                        avg_seeded[i] = 1'b1;
                    end
                    else if (tgt >= cur)
                        cur = cur + ((g * (tgt - cur)) >> 8);
                    else
                    begin
                        p = g * (cur - tgt);
                        cur = cur - ((p + 255) >> 8);
                    end
                    avg_q8[i] = cur[rmj_pkg::EMA_W-1:0];
                    res[i] = cur[rmj_pkg::EMA_W-1:rmj_pkg::FRAC_W];
                end
            end
        end
        return res;
    endfunction

    // Random frame: mostly readings near a drifting per-anchor base, plus
    // missing, out-of-range and full-range outliers
    function automatic frame_t rand_frame();
        frame_t f;
        int sel, v, spread;
        spread = (cfg_jump > 2000) ? 4000 : 2 * cfg_jump + 8;
        for (int i = 0; i < rmj_pkg::ANCHOR_SLOTS; i++)
        begin
            lane_base[i] = lane_base[i] + int'($urandom_range(0, 20)) - 10;
            if (lane_base[i] < 1)
                lane_base[i] = 1;
            if (lane_base[i] > 65535)
                lane_base[i] = 65535;
            sel = $urandom_range(0, 99);
            if (sel < 8)
                v = 0;
            else if (sel < 14)
                v = $urandom_range(0, 65535);
            else if (sel < 18)
                v = int'(cfg_vmax) + int'($urandom_range(0, 65535 - cfg_vmax));
            else
                v = lane_base[i] + int'($urandom_range(0, spread)) - spread / 2;
            if (v < 0)
                v = 1;
            if (v > 65535)
                v = 65535;
            f[i] = v[rmj_pkg::DIST_W-1:0];
        end
        return f;
    endfunction

    // Register write followed by a readback of the same register
    task automatic write_reg(rmj_pkg::cfg_reg_t idx, logic [rmj_pkg::PDATA_W-1:0] val);
        logic [rmj_pkg::PDATA_W-1:0] stored;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            rmj_pkg::REG_ANCHORS:   cfg_anchors = val[rmj_pkg::AIU_W-1:0];
            rmj_pkg::REG_MAX_JUMP:  cfg_jump    = val[rmj_pkg::DIST_W-1:0];
            rmj_pkg::REG_ALPHA:     cfg_alpha   = val[rmj_pkg::ALPHA_W-1:0];
            rmj_pkg::REG_VALID_MAX: cfg_vmax    = val[rmj_pkg::DIST_W-1:0];
            default: ;
        endcase
        case (idx)
            rmj_pkg::REG_ANCHORS:   stored = rmj_pkg::PDATA_W'(cfg_anchors);
            rmj_pkg::REG_MAX_JUMP:  stored = rmj_pkg::PDATA_W'(cfg_jump);
            rmj_pkg::REG_ALPHA:     stored = rmj_pkg::PDATA_W'(cfg_alpha);
            default:                stored = rmj_pkg::PDATA_W'(cfg_vmax);
        endcase
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== stored)
        begin
            $error("%s readback: expected %0d, actual %0d", idx.name(), stored, prdata);
            err_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_filter(int anchors, int jump, int alpha, int vmax);
        write_reg(rmj_pkg::REG_ANCHORS, anchors);
        write_reg(rmj_pkg::REG_MAX_JUMP, jump);
        write_reg(rmj_pkg::REG_ALPHA, alpha);
        write_reg(rmj_pkg::REG_VALID_MAX, vmax);
    endtask

    // One input transfer, with a random lead-in gap outside fast mode
    task automatic send_frame(frame_t raw);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 4);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        dist_drive <= raw;
        do @(posedge clk); while (!in_ready);
        pending_frames.push_back(filter_frame(raw));
    endtask

    // Drop valid and wait for every outstanding frame
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Result side: random stall per frame outside fast mode, optional long hold-off
    initial
    begin : result_check
        int stall;
        frame_t want;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req > 0)
            begin
                stall = hold_req;
                hold_req = 0;
            end
            else
                stall = fast_mode ? 0 : $urandom_range(0, 4);
            repeat (stall)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (pending_frames.size() == 0)
            begin
                $error("output transfer with no frame outstanding");
                err_count++;
            end
            else
            begin
                want = pending_frames.pop_front();
                for (int i = 0; i < rmj_pkg::ANCHOR_SLOTS; i++)
                begin
                    if (filt_seen[i] !== want[i])
                    begin
                        $error("filt_a%0d: expected %0d, actual %0d", i, want[i], filt_seen[i]);
                        err_count++;
                    end
                end
            end
        end
    end

    // Warm-up pass-through, short history, seeding, jumps at and past the limit
    task automatic test_warmup_history();
        frame_t f;
        for (int k = 0; k < 10; k++)
        begin
            f[0] = rmj_pkg::DIST_W'((k == 5) ? 9000 : 1000 + 10 * k);
            f[1] = rmj_pkg::DIST_W'((k % 2 == 1) ? 0 : 2000 + k);
            f[2] = rmj_pkg::DIST_W'((k >= 6) ? 3000 : 65535);
            f[3] = rmj_pkg::DIST_W'((k % 2 == 0) ? 49999 : 50000);
            f[4] = rmj_pkg::DIST_W'(1 + 200 * k);
            f[5] = rmj_pkg::DIST_W'((k * 7000) % 50000);
            f[6] = rmj_pkg::DIST_W'((k == 4) ? 30500 : ((k == 7) ? 30501 : 30000));
            f[7] = rmj_pkg::DIST_W'((k < 3) ? 0 : 12345 ^ k);
            send_frame(f);
        end
    endtask

    // Field extremes and bit patterns with the window full
    task automatic test_field_extremes();
        send_frame('0);
        send_frame({rmj_pkg::ANCHOR_SLOTS{16'hFFFF}});
        send_frame({rmj_pkg::ANCHOR_SLOTS{16'h0001}});
        send_frame({rmj_pkg::ANCHOR_SLOTS{16'd49999}});
        send_frame({rmj_pkg::ANCHOR_SLOTS / 2{16'hAAAA, 16'h5555}});
    endtask

    // Register settings in turn, extremes first, random frames in each
    task automatic test_random_phases();
        int hi;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: set_filter(1, 0, 1, 65535);
                1: set_filter(15, 65535, 256, 1);
                2: set_filter(0, 300, 511, 0);
                3: set_filter(8, 500, 0, 50000);
                4: set_filter(9, 1000, 255, 40000);
                default: set_filter($urandom_range(1, 15),
                                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                : $urandom_range(0, 3000),
                                    $urandom_range(0, 511),
                                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                : $urandom_range(20000, 65535));
            endcase
            fast_mode = (p % 4 == 2);
            hi = (cfg_vmax > 1) ? cfg_vmax - 1 : 1;
            for (int i = 0; i < rmj_pkg::ANCHOR_SLOTS; i++)
                lane_base[i] = $urandom_range(1, hi);
            for (int k = 0; k < PHASE_FRAMES; k++)
                send_frame(rand_frame());
        end
        fast_mode = 1'b0;
    endtask

    // Long output hold-off while frames keep coming, so the input stalls
    task automatic test_output_stall();
        wait_idle();
        set_filter(8, 400, 128, 50000);
        for (int i = 0; i < rmj_pkg::ANCHOR_SLOTS; i++)
            lane_base[i] = $urandom_range(1000, 40000);
        fast_mode = 1'b1;
        hold_req = HOLD_CYCLES;
        for (int k = 0; k < 30; k++)
            send_frame(rand_frame());
        fast_mode = 1'b0;
    endtask

    // Main sequence
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        dist_drive  = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        err_count   = 0;
        cycle_count = 0;
        hold_req    = 0;
        fast_mode   = 1'b0;
        win_frames  = 0;
        cfg_anchors = rmj_pkg::AIU_W'(rmj_pkg::AIU_RST);
        cfg_jump    = rmj_pkg::DIST_W'(rmj_pkg::JUMP_RST);
        cfg_alpha   = rmj_pkg::ALPHA_W'(rmj_pkg::ALPHA_RST);
        cfg_vmax    = rmj_pkg::DIST_W'(rmj_pkg::VMAX_RST);
        for (int i = 0; i < rmj_pkg::ANCHOR_SLOTS; i++)
        begin
            avg_q8[i]     = '0;
            avg_seeded[i] = 1'b0;
            lane_base[i]  = 1000;
            for (int w = 0; w < rmj_pkg::WIN_DEPTH; w++)
                win_hist[w][i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_warmup_history();
        test_field_extremes();
        test_random_phases();
        test_output_stall();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("range_median_jump_ema_filter_unit: match");
        else
            $display("range_median_jump_ema_filter_unit: mismatch");
        $finish;
    end

endmodule

>>> sim.f
rtl/rmj_pkg.sv
rtl/rmj_sort_cell.sv
rtl/rmj_sorter.sv
rtl/rmj_ema.sv
rtl/range_median_jump_ema_filter_unit.sv
tb/range_median_jump_ema_filter_unit_tb.sv
